### rtl/hpt_pkg.sv
// Shared types and constants for the HSV pixel tint pipeline.
// No dependencies; every other file refers to this package by scoped names.
package hpt_pkg;

  localparam int unsigned NumStages = 8;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHue   = 2'd0,
    CfgSat   = 2'd1,
    CfgLight = 2'd2,
    CfgLuma  = 2'd3
  } cfg_idx_e;

  // luma source codes; every other code selects green
  localparam logic [2:0] LumaRed  = 3'd1;
  localparam logic [2:0] LumaBlue = 3'd3;
  localparam logic [2:0] LumaMean = 3'd4;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic [6:0]        hue_setting;
    logic [6:0]        saturation_setting;
    logic signed [7:0] lightness_setting;
    logic [2:0]        luma_source;
  } cfg_t;

  // front end to conversion: gain product and hue/saturation terms
  typedef struct packed {
    logic [16:0] prod;
    logic [2:0]  sector;
    logic [14:0] hue50;
    logic [7:0]  sat;
  } front_t;

  // conversion to output stage: the candidate channel values
  typedef struct packed {
    logic [7:0] val;
    logic [7:0] lo;
    logic [7:0] fall;
    logic [7:0] rise;
    logic [2:0] sector;
  } conv_t;

  typedef logic [NumStages-1:0] stage_en_t;

endpackage

### rtl/hpt_ctrl.sv
// Pipeline control: per-stage valid bits and load enables with bubble collapsing.
// Depends on hpt_pkg.
module hpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output hpt_pkg::stage_en_t en_o
);

  localparam int unsigned N = hpt_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d, en;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[N-1] = !valid_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < N; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o        = en;
  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[N-1];

endmodule

### rtl/hpt_front.sv
// Front end, stages 0 and 1: source selection, gain product, hue and saturation terms.
// Depends on hpt_pkg.
module hpt_front (
  input  logic               clk_i,
  input  logic [1:0]         en_i,
  input  hpt_pkg::pix_in_t   pix_i,
  input  hpt_pkg::cfg_t      cfg_i,
  output hpt_pkg::front_t    front_o
);

  localparam logic [15:0] MeanMul   = 16'd43691;  // 2^17 / 3, rounded up
  localparam logic [10:0] SectorMul = 11'd1093;   // 2^16 / 60, rounded up
  localparam logic [8:0]  HueWrap   = 9'd360;

  // stage 0
  logic [9:0]        sum;
  logic [25:0]       mean_prod;
  logic [7:0]        src_d, src_q;
  logic [9:0]        hue_x7, sat_x5;
  logic [8:0]        hue_raw, sat_raw, hue_d, hue_q;
  logic [7:0]        sat_d, sat_q;
  logic signed [8:0] light_off;
  logic [8:0]        gain_d, gain_q;
  logic              gain_pos_d, gain_pos_q;

  always_comb begin
    sum       = 10'(pix_i.red_in) + 10'(pix_i.green_in) + 10'(pix_i.blue_in);
    mean_prod = 26'(sum) * 26'(MeanMul);
    case (cfg_i.luma_source)
      hpt_pkg::LumaRed:  src_d = pix_i.red_in;
      hpt_pkg::LumaBlue: src_d = pix_i.blue_in;
      hpt_pkg::LumaMean: src_d = mean_prod[24:17];
      default:           src_d = pix_i.green_in;
    endcase

    hue_x7  = (10'(cfg_i.hue_setting) << 3) - 10'(cfg_i.hue_setting);
    hue_raw = hue_x7[9:1];
    hue_d   = (hue_raw >= HueWrap) ? hue_raw - HueWrap : hue_raw;

    sat_x5  = (10'(cfg_i.saturation_setting) << 2) + 10'(cfg_i.saturation_setting);
    sat_raw = sat_x5[9:1];
    sat_d   = (sat_raw > 9'd255) ? 8'hFF : sat_raw[7:0];

    light_off  = {cfg_i.lightness_setting[7], cfg_i.lightness_setting} + 9'sd50;
    gain_pos_d = light_off > 9'sd0;
    gain_d     = {light_off[7:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      src_q      <= src_d;
      gain_q     <= gain_d;
      gain_pos_q <= gain_pos_d;
      hue_q      <= hue_d;
      sat_q      <= sat_d;
    end
  end

  // stage 1
  logic [19:0]     sec_prod;
  hpt_pkg::front_t front_d, front_q;

  always_comb begin
    sec_prod       = 20'(hue_q) * 20'(SectorMul);
    front_d.prod   = gain_pos_q ? 17'(gain_q) * 17'(src_q) : '0;
    front_d.sector = sec_prod[18:16];
    front_d.hue50  = 15'(hue_q) * 15'd50;
    front_d.sat    = sat_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

### rtl/hpt_hsv.sv
// HSV to RGB conversion, stages 2 to 6: value, sector fraction, falling and rising ramps.
// Depends on hpt_pkg.
module hpt_hsv (
  input  logic            clk_i,
  input  logic [4:0]      en_i,
  input  hpt_pkg::front_t front_i,
  output hpt_pkg::conv_t  conv_o
);

  localparam logic [17:0] Div255Mul  = 18'd131587;  // 2^25 / 255, rounded up
  localparam logic [18:0] Div1000Mul = 19'd268436;  // 2^28 / 1000, rounded up
  localparam logic [15:0] ThirdMul   = 16'd43691;   // 2^17 / 3, rounded up
  localparam logic [9:0]  FracOne    = 10'd1000;

  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [34:0] p;
    p = 35'(x) * 35'(Div255Mul);
    return p[33:25];
  endfunction

  function automatic logic [7:0] div1000(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'(Div1000Mul);
    return p[35:28];
  endfunction

  // stage 2: value and fraction in thousandths
  logic [8:0]  val_raw;
  logic [30:0] third_prod;
  logic [12:0] third, frac_w;
  logic [7:0]  val2_d, val2_q, sat2_q;
  logic [9:0]  frac2_q;
  logic [2:0]  sector2_q;

  always_comb begin
    val_raw    = div255(front_i.prod);
    val2_d     = (val_raw > 9'd255) ? 8'hFF : val_raw[7:0];
    third_prod = 31'(front_i.hue50) * 31'(ThirdMul);
    third      = third_prod[29:17];
    frac_w     = third - 13'(front_i.sector) * 13'd1000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      val2_q    <= val2_d;
      frac2_q   <= frac_w[9:0];
      sector2_q <= front_i.sector;
      sat2_q    <= front_i.sat;
    end
  end

  // stage 3: saturation products
  logic [9:0]  comp;
  logic [17:0] sf3_d, sr3_d, sf3_q, sr3_q;
  logic [15:0] lo_prod3_d, lo_prod3_q;
  logic [7:0]  val3_q;
  logic [2:0]  sector3_q;

  always_comb begin
    comp       = FracOne - frac2_q;
    sf3_d      = 18'(sat2_q) * 18'(frac2_q);
    sr3_d      = 18'(sat2_q) * 18'(comp);
    lo_prod3_d = 16'(8'hFF - sat2_q) * 16'(val2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sf3_q      <= sf3_d;
      sr3_q      <= sr3_d;
      lo_prod3_q <= lo_prod3_d;
      val3_q     <= val2_q;
      sector3_q  <= sector2_q;
    end
  end

  // stage 4: scale back from thousandths, finish the low channel
  logic [8:0] lo_w;
  logic [7:0] qf4_q, qr4_q, lo4_q, val4_q;
  logic [2:0] sector4_q;

  assign lo_w = div255(17'(lo_prod3_q));

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      qf4_q     <= div1000(sf3_q);
      qr4_q     <= div1000(sr3_q);
      lo4_q     <= lo_w[7:0];
      val4_q    <= val3_q;
      sector4_q <= sector3_q;
    end
  end

  // stage 5: ramp products
  logic [15:0] fall_prod_d, rise_prod_d, fall_prod5_q, rise_prod5_q;
  logic [7:0]  lo5_q, val5_q;
  logic [2:0]  sector5_q;

  always_comb begin
    fall_prod_d = 16'(8'hFF - qf4_q) * 16'(val4_q);
    rise_prod_d = 16'(8'hFF - qr4_q) * 16'(val4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      fall_prod5_q <= fall_prod_d;
      rise_prod5_q <= rise_prod_d;
      lo5_q        <= lo4_q;
      val5_q       <= val4_q;
      sector5_q    <= sector4_q;
    end
  end

  // stage 6: ramp quotients
  logic [8:0]     fall_w, rise_w;
  hpt_pkg::conv_t conv_d, conv_q;

  always_comb begin
    fall_w        = div255(17'(fall_prod5_q));
    rise_w        = div255(17'(rise_prod5_q));
    conv_d.val    = val5_q;
    conv_d.lo     = lo5_q;
    conv_d.fall   = fall_w[7:0];
    conv_d.rise   = rise_w[7:0];
    conv_d.sector = sector5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      conv_q <= conv_d;
    end
  end

  assign conv_o = conv_q;

endmodule

### rtl/hpt_out.sv
// Output stage 7: sector mux, red/blue swap, 1.5x boost with clamp, output register.
// Depends on hpt_pkg.
module hpt_out (
  input  logic              clk_i,
  input  logic              en_i,
  input  hpt_pkg::conv_t    conv_i,
  output hpt_pkg::pix_out_t pix_o
);

  function automatic logic [7:0] boost(input logic [7:0] c);
    logic [9:0] t;
    t = {1'b0, c, 1'b0} + 10'(c);
    return (t[9:1] > 9'd255) ? 8'hFF : t[8:1];
  endfunction

  logic [7:0]        cr, cg, cb;
  hpt_pkg::pix_out_t pix_d, pix_q;

  always_comb begin
    case (conv_i.sector)
      3'd0: begin
        cr = conv_i.val;  cg = conv_i.rise; cb = conv_i.lo;
      end
      3'd1: begin
        cr = conv_i.fall; cg = conv_i.val;  cb = conv_i.lo;
      end
      3'd2: begin
        cr = conv_i.lo;   cg = conv_i.val;  cb = conv_i.rise;
      end
      3'd3: begin
        cr = conv_i.lo;   cg = conv_i.fall; cb = conv_i.val;
      end
      3'd4: begin
        cr = conv_i.rise; cg = conv_i.lo;   cb = conv_i.val;
      end
      default: begin
        cr = conv_i.val;  cg = conv_i.lo;   cb = conv_i.fall;
      end
    endcase
    // red and blue trade places here
    pix_d.red_out   = boost(cb);
    pix_d.green_out = boost(cg);
    pix_d.blue_out  = boost(cr);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

### rtl/hsv_pixel_tint.sv
// Top level of the HSV pixel tint block: configuration registers and the pipeline.
// Depends on hpt_pkg, hpt_ctrl, hpt_front, hpt_hsv, hpt_out.
//
// Usage:
//   Pixels enter on in_valid_i/in_ready_o/in_data_i, one transfer per clock while ready.
//   Recolored pixels leave on out_valid_o/out_ready_i/out_data_o in order.
//   Settings are written on cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o
//   is always high. Write only while no pixel is in flight.
//   Path: a pixel transferred on the input passes through eight pipeline
//   registers, stages 0 to 7, before it shows on out_valid_o.
//   Throughput: one pixel per cycle while not stalled; eight stages hold one pixel each.
//   Stall: when out_ready_i is low the output holds; upstream stages keep
//   filling any empty slots, so in_ready_o drops only once every stage
//   holds a pixel. Nothing is dropped or repeated.
//   Reset: rst_ni clears all valid bits and the settings to zero.
module hsv_pixel_tint (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  hpt_pkg::pix_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output hpt_pkg::pix_out_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hpt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [7:0]                       cfg_data_i
);

  hpt_pkg::cfg_t      cfg_d, cfg_q;
  hpt_pkg::stage_en_t en;
  hpt_pkg::front_t    front;
  hpt_pkg::conv_t     conv;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (hpt_pkg::cfg_idx_e'(cfg_index_i))
        hpt_pkg::CfgHue:   cfg_d.hue_setting        = cfg_data_i[6:0];
        hpt_pkg::CfgSat:   cfg_d.saturation_setting = cfg_data_i[6:0];
        hpt_pkg::CfgLight: cfg_d.lightness_setting  = cfg_data_i;
        hpt_pkg::CfgLuma:  cfg_d.luma_source        = cfg_data_i[2:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .en_o        (en)
  );

  hpt_front u_front (
    .clk_i   (clk_i),
    .en_i    (en[1:0]),
    .pix_i   (in_data_i),
    .cfg_i   (cfg_q),
    .front_o (front)
  );

  hpt_hsv u_hsv (
    .clk_i   (clk_i),
    .en_i    (en[6:2]),
    .front_i (front),
    .conv_o  (conv)
  );

  hpt_out u_out (
    .clk_i  (clk_i),
    .en_i   (en[7]),
    .conv_i (conv),
    .pix_o  (out_data_o)
  );

endmodule

### rtl/hpt_checker.sv
// Port-level checks for hsv_pixel_tint, attached by the bind at the end.
// Depends on hpt_pkg and the top level's ports.
module hpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input hpt_pkg::pix_out_t           out_data_o
);

  logic [7:0] acc_hist_q, rdy_hist_q;

  // eight-bit shift-register histories of input transfers and output readiness
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_hist_q <= '0;
      rdy_hist_q <= '0;
    end else begin
      acc_hist_q <= {acc_hist_q[6:0], in_valid_i && in_ready_o};
      rdy_hist_q <= {rdy_hist_q[6:0], out_ready_i};
    end
  end

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before transfer");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out_data_o changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input not ready while output side is ready");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_hist_q[7] && (&rdy_hist_q[6:0]) |-> out_valid_o)
    else $error("pixel not delivered after eight unstalled cycles");

endmodule

bind hsv_pixel_tint hpt_checker u_hpt_checker (.*);
